>>> sv/swun_pkg.sv
// Shared types, constants and command/status structs for the synapse weight update unit.
package swun_pkg;

    localparam int LINKS       = 4;
    localparam int ROWS        = 64;
    localparam int UNITS       = 64;
    localparam int WEIGHT_BITS = 16;
    localparam int FRAC_BITS   = 12;

    localparam int LINK_W   = (LINKS > 1) ? $clog2(LINKS) : 1;
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int UNIT_W   = (UNITS > 1) ? $clog2(UNITS) : 1;
    localparam int NROWS    = LINKS * ROWS;
    localparam int NROW_W   = LINK_W + ROW_W;
    localparam int DEPTH    = NROWS * UNITS;
    localparam int ADDR_W   = NROW_W + UNIT_W;
    localparam int SUM_W    = WEIGHT_BITS + UNIT_W;
    localparam int DCNT_W   = $clog2(FRAC_BITS + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_UP         = 3'd0,
        CFG_STEP_DOWN       = 3'd1,
        CFG_PRUNE_THRESHOLD = 3'd2,
        CFG_MAINT_PERIOD    = 3'd3,
        CFG_UNITS_IN_USE    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [5:0] unit_index;
        logic [1:0] link_index;
        logic [5:0] source_row;
        logic       increment;
    } in_item_t;

    typedef struct packed {
        logic [15:0] new_weight;
        logic        rejected;
        logic        maintenance_ran;
    } out_item_t;

    typedef struct packed {
        logic clr_step;
        logic latch_in;
        logic rd_item;
        logic upd_item;
        logic rd_elem;
        logic acc;
        logic elem_load;
        logic div_step;
        logic wr_elem;
        logic col_next;
        logic col_clr;
        logic row_next;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic reject;
        logic maint_due;
        logic need_norm;
        logic div_last;
        logic col_last;
        logic row_last;
    } status_t;

endpackage

>>> sv/swun_ctrl.sv
// Controller state machine: sequences clearing, updates and the maintenance walk.
module swun_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  swun_pkg::status_t st,
    output swun_pkg::cmd_t    cmd
);
    import swun_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_RD, S_UPD, S_SUM_RD, S_SUM_ACC,
        S_M_RD, S_M_LD, S_M_DIV, S_M_WR, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
                state_next = st.reject ? S_DONE : S_RD;
            S_RD:
            begin
                cmd.rd_item = 1'b1;
                state_next  = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd_item = 1'b1;
                state_next   = st.maint_due ? S_SUM_RD : S_DONE;
            end
            S_SUM_RD:
            begin
                cmd.rd_elem = 1'b1;
                state_next  = S_SUM_ACC;
            end
            S_SUM_ACC:
            begin
                cmd.acc = 1'b1;
                if (st.col_last)
                begin
                    cmd.col_clr = 1'b1;
                    state_next  = S_M_RD;
                end
                else
                begin
                    cmd.col_next = 1'b1;
                    state_next   = S_SUM_RD;
                end
            end
            S_M_RD:
            begin
                cmd.rd_elem = 1'b1;
                state_next  = S_M_LD;
            end
            S_M_LD:
            begin
                cmd.elem_load = 1'b1;
                state_next    = st.need_norm ? S_M_DIV : S_M_WR;
            end
            S_M_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                    state_next = S_M_WR;
            end
            S_M_WR:
            begin
                cmd.wr_elem = 1'b1;
                if (st.col_last)
                begin
                    cmd.col_clr = 1'b1;
                    if (st.row_last)
                        state_next = S_DONE;
                    else
                    begin
                        cmd.row_next = 1'b1;
                        state_next   = S_SUM_RD;
                    end
                end
                else
                begin
                    cmd.col_next = 1'b1;
                    state_next   = S_M_RD;
                end
            end
            S_DONE:
            begin
                // hold the result until the output slot frees up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/swun_dp.sv
// Datapath: weight memory, config registers, counters, row sum and serial divider.
module swun_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  swun_pkg::in_item_t    in_data,
    output swun_pkg::out_item_t   out_data,
    input  swun_pkg::cmd_t        cmd,
    output swun_pkg::status_t     st
);
    import swun_pkg::*;

    logic [WEIGHT_BITS-1:0] mem [DEPTH];
    logic [WEIGHT_BITS-1:0] rdata_reg;

    logic [15:0] step_up_reg, step_down_reg, prune_reg, period_reg;
    logic [6:0]  units_reg;
    logic [16:0] counter_reg;

    in_item_t    item_reg;
    logic        rej_reg, ran_reg;
    logic [WEIGHT_BITS-1:0] res_w_reg;
    out_item_t   out_reg;

    logic [ADDR_W-1:0] clr_addr_reg;
    logic [UNIT_W-1:0] col_reg;
    logic [NROW_W-1:0] row_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W:0]    rem_reg;
    logic [WEIGHT_BITS-1:0] work_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic              norm_reg;

    logic [6:0]        cols;
    logic              reject;
    logic [ADDR_W-1:0] item_addr, elem_addr, raddr, waddr;
    logic [WEIGHT_BITS:0]   up_sum;
    logic [WEIGHT_BITS-1:0] upd_w, wdata, pruned;
    logic              we;
    logic              due;
    logic              col_last;
    logic [SUM_W:0]    rem_sh;

    assign cols = (units_reg > 7'(UNITS)) ? 7'(UNITS) : units_reg;
    assign reject = ({1'b0, in_data.unit_index} >= cols)
                 || (32'(in_data.link_index) >= 32'(LINKS))
                 || (32'(in_data.source_row) >= 32'(ROWS));

    assign item_addr = {item_reg.link_index[LINK_W-1:0], item_reg.source_row[ROW_W-1:0],
                        item_reg.unit_index[UNIT_W-1:0]};
    assign elem_addr = {row_reg, col_reg};
    assign raddr     = cmd.rd_item ? item_addr : elem_addr;

    assign up_sum = {1'b0, rdata_reg} + (WEIGHT_BITS+1)'(step_up_reg);
    always_comb
    begin
        if (item_reg.increment)
            upd_w = up_sum[WEIGHT_BITS] ? '1 : up_sum[WEIGHT_BITS-1:0];
        else if (32'(rdata_reg) > 32'(step_down_reg))
            upd_w = WEIGHT_BITS'(32'(rdata_reg) - 32'(step_down_reg));
        else
            upd_w = '0;
    end

    assign due      = counter_reg > {1'b0, period_reg};
    assign pruned   = (32'(work_reg) < 32'(prune_reg)) ? '0 : work_reg;
    assign col_last = ({1'b0, col_reg} == cols - 7'd1);

    always_comb
    begin
        we    = 1'b0;
        waddr = elem_addr;
        wdata = pruned;
        if (cmd.clr_step)
        begin
            we    = 1'b1;
            waddr = clr_addr_reg;
            wdata = '0;
        end
        else if (cmd.upd_item)
        begin
            we    = 1'b1;
            waddr = item_addr;
            wdata = upd_w;
        end
        else if (cmd.wr_elem)
            we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (cmd.rd_item || cmd.rd_elem)
            rdata_reg <= mem[raddr];
    end

    assign rem_sh = {rem_reg[SUM_W-1:0], 1'b0};

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            item_reg  <= in_data;
            rej_reg   <= reject;
            res_w_reg <= '0;
            ran_reg   <= 1'b0;
        end
        if (cmd.upd_item)
        begin
            res_w_reg <= upd_w;
            ran_reg   <= due;
        end
        if (cmd.load_out)
            out_reg <= '{new_weight: 16'(res_w_reg), rejected: rej_reg,
                         maintenance_ran: ran_reg};
        if (cmd.elem_load)
        begin
            dcnt_reg <= '0;
            if (norm_reg)
            begin
                if ({{(SUM_W-WEIGHT_BITS){1'b0}}, rdata_reg} >= sum_reg)
                begin
                    rem_reg  <= (SUM_W+1)'(rdata_reg) - {1'b0, sum_reg};
                    work_reg <= WEIGHT_BITS'(1);
                end
                else
                begin
                    rem_reg  <= (SUM_W+1)'(rdata_reg);
                    work_reg <= '0;
                end
            end
            else
                work_reg <= rdata_reg;
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + 1'b1;
            if (rem_sh >= {1'b0, sum_reg})
            begin
                rem_reg  <= rem_sh - {1'b0, sum_reg};
                work_reg <= {work_reg[WEIGHT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                work_reg <= {work_reg[WEIGHT_BITS-2:0], 1'b0};
            end
        end
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_up_reg   <= '0;
            step_down_reg <= '0;
            prune_reg     <= '0;
            period_reg    <= 16'd100;
            units_reg     <= 7'd64;
            counter_reg   <= '0;
            clr_addr_reg  <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            sum_reg       <= '0;
            norm_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STEP_UP:         step_up_reg   <= cfg_data;
                    CFG_STEP_DOWN:       step_down_reg <= cfg_data;
                    CFG_PRUNE_THRESHOLD: prune_reg     <= cfg_data;
                    CFG_MAINT_PERIOD:    period_reg    <= cfg_data;
                    CFG_UNITS_IN_USE:    units_reg     <= cfg_data[6:0];
                    default:             ;
                endcase
            end
            if (cmd.clr_step)
                clr_addr_reg <= clr_addr_reg + 1'b1;
            if (cmd.upd_item)
            begin
                counter_reg <= (due ? 17'd0 : counter_reg) + 17'd1;
                col_reg     <= '0;
                row_reg     <= '0;
                sum_reg     <= '0;
            end
            if (cmd.acc)
                sum_reg <= sum_reg + SUM_W'(rdata_reg);
            if (cmd.acc && col_last)
                norm_reg <= (sum_reg + SUM_W'(rdata_reg)) > SUM_W'(1 << FRAC_BITS);
            if (cmd.col_next)
                col_reg <= col_reg + 1'b1;
            else if (cmd.col_clr)
                col_reg <= '0;
            if (cmd.row_next)
            begin
                row_reg <= row_reg + 1'b1;
                sum_reg <= '0;
            end
        end
    end

    assign st = '{clear_last: (32'(clr_addr_reg) == DEPTH - 1),
                  reject:     rej_reg,
                  maint_due:  due,
                  need_norm:  norm_reg,
                  div_last:   (32'(dcnt_reg) == FRAC_BITS - 1),
                  col_last:   col_last,
                  row_last:   (32'(row_reg) == NROWS - 1)};

    assign out_data = out_reg;

endmodule

>>> sv/synapse_weight_update_normalize_unit.sv
// Top level of the synapse weight update unit: controller plus datapath.
//
// One input transaction names a synapse (link, source row, unit column) and a
// direction; one output transaction returns the updated weight, a reject flag
// and a flag telling whether the normalize/prune pass ran. Both channels use
// valid/ready; the user must write configuration registers through cfg_we,
// cfg_index and cfg_data only while the unit is idle; the unit does not enforce it.
// After an input is accepted, an ordinary transaction passes through check,
// memory read, modify/write and result load before out_valid rises; a rejected
// one goes from check straight to result load. The weight memory read-modify-write
// sets this sequence, and one transaction is in flight at a time.
// When the call counter passes the maintenance period the transaction also walks
// all LINKS*ROWS rows: per row it reads and accumulates each column in use for
// the sum, then reads, loads and writes back each such column to prune, running
// the serial divider on each column as well when the row sum exceeds 1.0.
// After reset the memory is cleared one entry a cycle over all 16384 entries,
// during which in_ready stays low. A stalled receiver holds the result in the output
// register; the next transaction may be accepted but its result waits for it.
module synapse_weight_update_normalize_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  swun_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output swun_pkg::out_item_t  out_data,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import swun_pkg::*;

    cmd_t    cmd;
    status_t st;

    swun_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    swun_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_data  (out_data),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

>>> verif/tb_synapse_weight_update_normalize_unit.sv
// Self-checking testbench for the synapse weight update and normalize unit.
module tb_synapse_weight_update_normalize_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import swun_pkg::*;

    localparam int STALL_LIMIT = 1500000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [15:0] cfg_data = 16'd0;

    // shadow of the unit: weight store, call counter and registers
    logic [15:0] weights [0:DEPTH-1];
    logic [16:0] call_count;
    logic [15:0] step_up, step_down, prune_level, period;
    logic [6:0]  units_used;

    in_item_t    pending_updates [$];
    out_item_t   expected_results [$];
    int          errors = 0;
    int          send_idle_pct = 9;
    int          recv_idle_pct = 75;
    int          idle_cycles = 0;

    synapse_weight_update_normalize_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int cols_in_use();
        return (units_used > UNITS) ? UNITS : int'(units_used);
    endfunction

    // normalize every row whose sum passes 1.0, then prune small weights
    function automatic void renorm_and_prune();
        int     cols;
        int     base;
        longint sum;
        cols = cols_in_use();
        for (int r = 0; r < NROWS; r++)
        begin
            base = r * UNITS;
            sum = 0;
            for (int u = 0; u < cols; u++)
                sum += weights[base + u];
            if (sum > (longint'(1) << FRAC_BITS))
                for (int u = 0; u < cols; u++)
                    weights[base + u] = 16'((longint'(weights[base + u]) << FRAC_BITS) / sum);
            for (int u = 0; u < cols; u++)
                if (weights[base + u] < prune_level)
                    weights[base + u] = '0;
        end
    endfunction

    function automatic out_item_t predict_update(in_item_t it);
        out_item_t   res;
        int          addr;
        logic [16:0] w;
        res = '0;
        if (int'(it.unit_index) >= cols_in_use())
        begin
            res.rejected = 1'b1;
            return res;
        end
        addr = int'({it.link_index, it.source_row, it.unit_index});
        if (it.increment)
        begin
            w = {1'b0, weights[addr]} + {1'b0, step_up};
            if (w[16])
                w = 17'hFFFF;
        end
        else
            w = (weights[addr] > step_down) ? {1'b0, weights[addr] - step_down} : '0;
        weights[addr] = w[15:0];
        if (call_count > {1'b0, period})
        begin
            renorm_and_prune();
            call_count = '0;
            res.maintenance_ran = 1'b1;
        end
        call_count = call_count + 17'd1;
        res.new_weight = w[15:0];
        return res;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
        errors++;
    endtask

    task automatic add_item(in_item_t it);
        pending_updates.insert(pending_updates.size(), it);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_STEP_UP:         step_up = value;
            CFG_STEP_DOWN:       step_down = value;
            CFG_PRUNE_THRESHOLD: prune_level = value;
            CFG_MAINT_PERIOD:    period = value;
            CFG_UNITS_IN_USE:    units_used = value[6:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(logic [15:0] up, logic [15:0] down, logic [15:0] prune,
                            logic [15:0] per, logic [6:0] units);
        write_reg(CFG_STEP_UP, up);
        write_reg(CFG_STEP_DOWN, down);
        write_reg(CFG_PRUNE_THRESHOLD, prune);
        write_reg(CFG_MAINT_PERIOD, per);
        write_reg(CFG_UNITS_IN_USE, {9'd0, units});
    endtask

    // hold the sender until every expected result is back, then settle
    task automatic drain();
        wait (pending_updates.size() == 0 && expected_results.size() == 0 && !in_valid);
        repeat (12) @(posedge clk);
    endtask

    function automatic in_item_t make_item(int unit, int link, int row, bit up);
        in_item_t it;
        it.unit_index = unit[5:0];
        it.link_index = link[1:0];
        it.source_row = row[5:0];
        it.increment  = up;
        return it;
    endfunction

    // mostly hit a few hot rows so sums grow past 1.0; some out-of-range units
    task automatic queue_random(int count);
        int cols;
        int unit;
        in_item_t it;
        cols = cols_in_use();
        for (int i = 0; i < count; i++)
        begin
            if (cols > 0 && $urandom_range(99) < 85)
                unit = int'($urandom_range(cols - 1));
            else
                unit = int'($urandom_range(63));
            if ($urandom_range(99) < 70)
                it = make_item(unit, int'($urandom_range(1)), int'($urandom_range(3)),
                               $urandom_range(99) < 65);
            else
                it = make_item(unit, int'($urandom_range(3)), int'($urandom_range(63)),
                               $urandom_range(1) == 1);
            add_item(it);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.insert(expected_results.size(), predict_update(in_data));
            if (!in_valid || in_ready)
            begin
                if (pending_updates.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_updates.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result transaction", 1, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.new_weight !== want.new_weight)
                        report_mismatch("new_weight", int'(out_data.new_weight),
                                        int'(want.new_weight));
                    if (out_data.rejected !== want.rejected)
                        report_mismatch("rejected", int'(out_data.rejected),
                                        int'(want.rejected));
                    if (out_data.maintenance_ran !== want.maintenance_ran)
                        report_mismatch("maintenance_ran", int'(out_data.maintenance_ran),
                                        int'(want.maintenance_ran));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: long maintenance passes accept nothing for many cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("synapse_weight_update_normalize_unit regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        foreach (weights[i])
            weights[i] = '0;
        call_count  = '0;
        step_up     = '0;
        step_down   = '0;
        prune_level = '0;
        period      = 16'd100;
        units_used  = 7'd64;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: normalize a hot row, reject out of range, hit both clamps
        set_regs(16'h0C00, 16'h0400, 16'h0200, 16'd1, 7'd2);
        add_item(make_item(0, 0, 0, 1));
        add_item(make_item(1, 0, 0, 1));
        add_item(make_item(1, 0, 0, 1));
        add_item(make_item(2, 0, 0, 1));
        add_item(make_item(63, 3, 63, 1));
        add_item(make_item(0, 3, 63, 1));
        for (int i = 0; i < 4; i++)
            add_item(make_item(0, 3, 63, 0));
        add_item(make_item(1, 0, 0, 0));
        drain();
        set_regs(16'hFFFF, 16'h0000, 16'hFFFF, 16'd0, 7'd2);
        add_item(make_item(1, 3, 63, 1));
        add_item(make_item(1, 3, 63, 1));
        add_item(make_item(1, 3, 63, 0));
        add_item(make_item(0, 1, 5, 1));
        drain();
        set_regs(16'h0000, 16'hFFFF, 16'h0000, 16'd1, 7'd64);
        add_item(make_item(63, 2, 17, 1));
        add_item(make_item(63, 2, 17, 0));
        add_item(make_item(40, 1, 5, 0));
        drain();

        set_regs(16'($urandom_range(16'h2000)), 16'($urandom_range(16'h1000)),
                 16'($urandom_range(16'h0300)), 16'd30, 7'd4);
        queue_random(250);
        drain();

        send_idle_pct = 75;
        recv_idle_pct = 9;
        set_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 7'd0);
        queue_random(20);
        drain();
        set_regs(16'($urandom_range(16'h1800)), 16'($urandom_range(16'h1800)),
                 16'h0000, 16'hFFFF, 7'd127);
        queue_random(200);
        drain();
        set_regs(16'($urandom_range(16'h3000)), 16'($urandom_range(16'h0800)),
                 16'($urandom_range(16'h0400)), 16'd0, 7'd1);
        queue_random(100);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_regs(16'($urandom_range(16'h1000)), 16'($urandom_range(16'h0C00)),
                 16'($urandom_range(16'h0100)), 16'd60, 7'd16);
        queue_random(250);
        drain();
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("synapse_weight_update_normalize_unit regression: pass");
        else
            $display("synapse_weight_update_normalize_unit regression: fail");
        $finish;
    end

endmodule

>>> synapse_weight_update_normalize_unit.f
sv/swun_pkg.sv
sv/swun_ctrl.sv
sv/swun_dp.sv
sv/synapse_weight_update_normalize_unit.sv
verif/tb_synapse_weight_update_normalize_unit.sv
